// ----- rtl/core/i2cbb_pkg.sv -----
`default_nettype none

package i2cbb_pkg;

    // Command codes carried in the cmd field
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Register map
    localparam int         CFG_AW          = 3;
    localparam logic [0:0] REG_TICKS_PER_US = 1'b0;
    localparam logic [0:0] REG_ACK_LIMIT    = 1'b1;
    localparam logic [9:0] TICKS_RESET      = 10'd72;
    localparam logic [15:0] ACK_LIMIT_RESET = 16'd250;

    localparam int         DLY_W    = 12;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_SP_A    = 4'd3,
        PH_SP_B    = 4'd4,
        PH_WA_A    = 4'd5,
        PH_WA_B    = 4'd6,
        PH_WA_POLL = 4'd7,
        PH_TX_A    = 4'd8,
        PH_TX_B    = 4'd9,
        PH_TX_C    = 4'd10,
        PH_RD_A    = 4'd11,
        PH_RD_B    = 4'd12,
        PH_RK_A    = 4'd13,
        PH_RK_B    = 4'd14
    } i2cbb_phase_t;

    typedef struct packed {
        i2cbb_phase_t     phase;
        logic [2:0]       active_cmd;
        logic [DLY_W-1:0] delay_count;
        logic [3:0]       bit_count;
        logic [7:0]       shift;
        logic [15:0]      poll_count;
        logic             ack_choice;
        logic             scl;
        logic             sda;
        logic             drive;
        logic [7:0]       rx;
        logic             fail;
    } i2cbb_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } i2cbb_item_t;

    typedef struct packed {
        logic [9:0]  ticks_per_us;
        logic [15:0] ack_limit;
    } i2cbb_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2cbb_cfg.sv -----
`default_nettype none

module i2cbb_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cbb_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output i2cbb_pkg::i2cbb_cfg_t            cfg
);
    import i2cbb_pkg::*;

    logic [9:0]  tpu_reg;
    logic [15:0] lim_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TICKS_RESET;
            lim_reg <= ACK_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_TICKS_PER_US)
                tpu_reg <= pwdata[9:0];
            else
                lim_reg <= pwdata[15:0];
        end
    end

    // Unaligned reads return zero
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_TICKS_PER_US)
                prdata = {22'd0, tpu_reg};
            else
                prdata = {16'd0, lim_reg};
        end
    end

    assign cfg.ticks_per_us = tpu_reg;
    assign cfg.ack_limit    = lim_reg;

endmodule

`default_nettype wire

// ----- rtl/core/i2cbb_step.sv -----
`default_nettype none

module i2cbb_step (
    input  i2cbb_pkg::i2cbb_state_t st,
    input  i2cbb_pkg::i2cbb_item_t  item,
    input  i2cbb_pkg::i2cbb_cfg_t   cfg,
    output i2cbb_pkg::i2cbb_state_t nx,
    output logic                    done
);
    import i2cbb_pkg::*;

    logic [9:0]       tick;
    logic [DLY_W-1:0] dly1;
    logic [DLY_W-1:0] dly2;
    logic [DLY_W-1:0] dly4;

    // Zero ticks per microsecond acts as one
    assign tick = (cfg.ticks_per_us == 10'd0) ? 10'd1 : cfg.ticks_per_us;
    assign dly1 = {2'b00, tick};
    assign dly2 = {1'b0, tick, 1'b0};
    assign dly4 = {tick, 2'b00};

    always_comb
    begin
        nx   = st;
        done = 1'b0;
        if (st.phase == PH_WA_POLL)
        begin
            if (!item.sda_in)
            begin
                nx.scl  = 1'b0;
                nx.fail = 1'b0;
                done    = 1'b1;
            end
            else if (st.poll_count >= cfg.ack_limit)
            begin
                nx.drive       = 1'b1;
                nx.scl         = 1'b0;
                nx.sda         = 1'b0;
                nx.delay_count = dly4;
                nx.phase       = PH_SP_A;
            end
            else
            begin
                nx.poll_count = st.poll_count + 16'd1;
            end
        end
        else if (st.phase inside {[PH_ST_A:PH_RK_B]})
        begin
            if (st.delay_count > DLY_W'(1))
            begin
                nx.delay_count = st.delay_count - DLY_W'(1);
            end
            else
            begin
                case (st.phase)
                    PH_ST_A:
                    begin
                        nx.sda = 1'b0; nx.delay_count = dly4; nx.phase = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        nx.scl = 1'b0; done = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        nx.scl = 1'b1; nx.sda = 1'b1;
                        nx.delay_count = dly4; nx.phase = PH_SP_B;
                    end
                    PH_SP_B:
                    begin
                        if (st.active_cmd == CMD_WAIT)
                            nx.fail = 1'b1;
                        done = 1'b1;
                    end
                    PH_WA_A:
                    begin
                        nx.scl = 1'b1; nx.delay_count = dly1; nx.phase = PH_WA_B;
                    end
                    PH_WA_B:
                    begin
                        nx.phase = PH_WA_POLL;
                    end
                    PH_TX_A:
                    begin
                        nx.scl = 1'b1; nx.delay_count = dly2; nx.phase = PH_TX_B;
                    end
                    PH_TX_B:
                    begin
                        nx.scl = 1'b0; nx.delay_count = dly2; nx.phase = PH_TX_C;
                    end
                    PH_TX_C:
                    begin
                        nx.bit_count = st.bit_count + 4'd1;
                        if (nx.bit_count >= BITS_PER_BYTE)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            nx.sda         = st.shift[7];
                            nx.shift       = {st.shift[6:0], 1'b0};
                            nx.delay_count = dly2;
                            nx.phase       = PH_TX_A;
                        end
                    end
                    PH_RD_A:
                    begin
                        nx.scl         = 1'b1;
                        nx.shift       = {st.shift[6:0], item.sda_in};
                        nx.bit_count   = st.bit_count + 4'd1;
                        nx.delay_count = dly1;
                        nx.phase       = PH_RD_B;
                    end
                    PH_RD_B:
                    begin
                        nx.scl         = 1'b0;
                        nx.delay_count = dly2;
                        if (st.bit_count >= BITS_PER_BYTE)
                        begin
                            nx.drive = 1'b1;
                            nx.sda   = !st.ack_choice;
                            nx.phase = PH_RK_A;
                        end
                        else
                        begin
                            nx.phase = PH_RD_A;
                        end
                    end
                    PH_RK_A:
                    begin
                        nx.scl = 1'b1; nx.delay_count = dly2; nx.phase = PH_RK_B;
                    end
                    PH_RK_B:
                    begin
                        nx.scl = 1'b0; nx.rx = st.shift; done = 1'b1;
                    end
                    default:
                    begin
                        nx = st;
                    end
                endcase
            end
        end
        else
        begin
            // Idle, or a stray phase code that counts as idle
            nx.phase = PH_IDLE;
            if (item.cmd inside {[CMD_START:CMD_READ]})
            begin
                nx.active_cmd = item.cmd;
                case (item.cmd)
                    CMD_START:
                    begin
                        nx.drive = 1'b1; nx.sda = 1'b1; nx.scl = 1'b1;
                        nx.delay_count = dly4; nx.phase = PH_ST_A;
                    end
                    CMD_STOP:
                    begin
                        nx.drive = 1'b1; nx.scl = 1'b0; nx.sda = 1'b0;
                        nx.delay_count = dly4; nx.phase = PH_SP_A;
                    end
                    CMD_SEND:
                    begin
                        nx.drive       = 1'b1;
                        nx.scl         = 1'b0;
                        nx.sda         = item.tx_byte[7];
                        nx.shift       = {item.tx_byte[6:0], 1'b0};
                        nx.bit_count   = 4'd0;
                        nx.delay_count = dly2;
                        nx.phase       = PH_TX_A;
                    end
                    CMD_WAIT:
                    begin
                        nx.drive = 1'b0; nx.sda = 1'b1; nx.poll_count = 16'd0;
                        nx.delay_count = dly1; nx.phase = PH_WA_A;
                    end
                    default:
                    begin
                        nx.drive       = 1'b0;
                        nx.scl         = 1'b0;
                        nx.ack_choice  = item.send_ack;
                        nx.shift       = 8'd0;
                        nx.bit_count   = 4'd0;
                        nx.delay_count = dly2;
                        nx.phase       = PH_RD_A;
                    end
                endcase
            end
        end
        if (done)
            nx.phase = PH_IDLE;
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_bitbang_master_unit.sv -----
`default_nettype none
// A tick transaction held in the input register goes through the step logic into the result
// slot when it is free or being emptied (input register, step logic, result register).
// Throughput: one tick item per cycle unless m_tready stalls; bus state steps once per item.
// The step logic (pin sequencer plus delay counter) is one short combinational pass.
// Reset (rst_n, asynchronous, active low): sequencer idle, SCL low, SDA high and driven,
// ticks_per_us 72, ack_limit 250, both pipeline stages empty.
module i2c_bitbang_master_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input tick stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [2:0] cmd, [10:3] tx_byte, [11] send_ack, [12] sda_in, [15:13] zero
    input  wire logic [15:0]                  s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [13] ack_failed, [15:14] zero
    output logic      [15:0]                  m_tdata,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [i2cbb_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import i2cbb_pkg::*;

    i2cbb_cfg_t   cfg;
    i2cbb_item_t  in_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic [15:0]  out_reg;
    i2cbb_state_t state_reg;
    i2cbb_state_t state_next;
    logic         step_done;
    logic         advance;

    i2cbb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cbb_step u_step (
        .st   (state_reg),
        .item (in_reg),
        .cfg  (cfg),
        .nx   (state_next),
        .done (step_done)
    );

    // Advance the held tick into the sequencer whenever the result slot is free
    // or being emptied this cycle; the input stage refills in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.cmd      <= s_tdata[2:0];
            in_reg.tx_byte  <= s_tdata[10:3];
            in_reg.send_ack <= s_tdata[11];
            in_reg.sda_in   <= s_tdata[12];
        end
    end

    // Bus state moves only when a tick is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.active_cmd  <= CMD_NONE;
            state_reg.delay_count <= '0;
            state_reg.bit_count   <= 4'd0;
            state_reg.shift       <= 8'd0;
            state_reg.poll_count  <= 16'd0;
            state_reg.ack_choice  <= 1'b0;
            state_reg.scl         <= 1'b0;
            state_reg.sda         <= 1'b1;
            state_reg.drive       <= 1'b1;
            state_reg.rx          <= 8'd0;
            state_reg.fail        <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result slot: hold until taken, drop when taken without a refill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= {2'b00, state_next.fail, state_next.rx, step_done,
                        (state_next.phase != PH_IDLE), state_next.drive,
                        state_next.sda, state_next.scl};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // A finishing command never reports itself busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg[4] |-> !out_reg[3])
        else $error("done_res with busy_res set");

    // The shown busy flag tracks the sequencer state that produced it
    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg[3] == (state_reg.phase != PH_IDLE)))
        else $error("busy_res out of step with sequencer");

    // Bit counter never runs past one byte
    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= BITS_PER_BYTE)
        else $error("bit counter overran a byte");

    // A consumed tick always yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("consumed tick produced no result");

endmodule

`default_nettype wire
